FILE: src/skc_pkg.sv
// Shared constants, codes, types and tables of the soft-knee compressor.
package skc_pkg;

  localparam int SAMPLE_BITS = 24;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_RATIO = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_GAIN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ATTACK    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS  = 3'd5;

  localparam logic [14:0] THRESHOLD_RST = 15'h6B00;  // -21 dB
  localparam logic [15:0] INV_RATIO_RST = 16'd13797;
  localparam logic [15:0] OUT_GAIN_RST  = 16'd8173;
  localparam logic [23:0] ATTACK_RST    = 24'd16753930;
  localparam logic [23:0] RELEASE_RST   = 24'd16776517;
  localparam logic [1:0]  CHANNELS_RST  = 2'd2;

  // dB values are Q16 inside the envelope path
  localparam int ENV_W = 24;
  localparam logic signed [ENV_W-1:0] DB_FLOOR = -24'sd6553600;
  localparam logic [31:0] DB_PER_OCTAVE  = 32'd394566;
  localparam logic [31:0] OCTAVE_PER_DB  = 32'd2786635;
  localparam logic [12:0] RED_MAX        = 13'd8191;

  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  typedef enum logic [3:0] {
    ST_IDLE, ST_NORM, ST_SQUARE, ST_DB, ST_ENV, ST_KNEE, ST_GR_HI, ST_GR_LO,
    ST_RED, ST_EXP, ST_GAIN, ST_TOTAL, ST_OUT_L, ST_OUT_R, ST_DONE
  } skc_state_t;

  // 2^-(2^-(i+1)) in Q24
  function automatic logic [23:0] exp2_neg(input logic [3:0] i);
    logic [23:0] v;
    case (i)
      4'd0:    v = 24'd11863283;
      4'd1:    v = 24'd14107901;
      4'd2:    v = 24'd15384775;
      4'd3:    v = 24'd16065916;
      4'd4:    v = 24'd16417715;
      4'd5:    v = 24'd16596492;
      4'd6:    v = 24'd16686609;
      4'd7:    v = 24'd16731851;
      4'd8:    v = 24'd16754518;
      4'd9:    v = 24'd16765863;
      4'd10:   v = 24'd16771539;
      4'd11:   v = 24'd16774377;
      4'd12:   v = 24'd16775796;
      4'd13:   v = 24'd16776506;
      4'd14:   v = 24'd16776861;
      4'd15:   v = 24'd16777039;
      default: v = 24'd16777039;
    endcase
    return v;
  endfunction

endpackage

FILE: src/skc_if.sv
// Frame channels of the soft-knee compressor: input samples and results.
interface skc_frame_in_if;
  logic valid;
  logic ready;
  logic signed [skc_pkg::SAMPLE_BITS-1:0] sample_left;
  logic signed [skc_pkg::SAMPLE_BITS-1:0] sample_right;
  modport source(output valid, output sample_left, output sample_right, input ready);
  modport sink(input valid, input sample_left, input sample_right, output ready);
endinterface

interface skc_frame_out_if;
  logic valid;
  logic ready;
  logic signed [skc_pkg::SAMPLE_BITS-1:0] out_left;
  logic signed [skc_pkg::SAMPLE_BITS-1:0] out_right;
  logic [12:0] reduction_db;
  logic        clipped;
  modport source(output valid, output out_left, output out_right, output reduction_db,
                 output clipped, input ready);
  modport sink(input valid, input out_left, input out_right, input reduction_db,
               input clipped, output ready);
endinterface

FILE: src/soft_knee_compressor_top.sv
// Soft-knee compressor: detector, dB envelope, knee curve and gain on one shared multiplier.
//
//  channel   dir  handshake        payload
//  in_ch     in   valid/ready      sample_left, sample_right
//  out_ch    out  valid/ready      out_left, out_right, reduction_db, clipped
//  cfg       in   cfg_we           cfg_index, cfg_data
//
// out_ch.valid rises once the frame has passed all states, later when the envelope sits
// inside the knee (ST_GR_HI, ST_GR_LO); a new frame is taken only after the last one is
// handed over. 16 squaring steps of the log2 and 16 steps of the exp2 run on the single
// 32x32 multiplier. in_ch.ready is high only in idle; a pending result in the output
// register does not block the next accept, only the hand-over at the end of the next frame.
// rst is synchronous: configuration registers return to their reset values and envelope to -100 dB.
module soft_knee_compressor_top (
  input  logic                            clk,
  input  logic                            rst,
  skc_frame_in_if.sink                    in_ch,
  skc_frame_out_if.source                 out_ch,
  input  logic                            cfg_we,
  input  logic [skc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [skc_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int SB    = skc_pkg::SAMPLE_BITS;
  localparam int P_W   = $clog2(SB);
  localparam int NEG_W = P_W + 16;
  localparam int EW    = skc_pkg::ENV_W;
  localparam int Y_W   = SB + 4;

  skc_pkg::skc_state_t state, state_next;

  // configuration
  logic [14:0] threshold_db;
  logic [15:0] inverse_ratio;
  logic [15:0] output_gain;
  logic [23:0] attack_coeff;
  logic [23:0] release_coeff;
  logic [1:0]  channel_count;

  // datapath registers
  logic [SB-1:0]        mag_l, mag_r;
  logic                 neg_l, neg_r, zero_l;
  logic [P_W-1:0]       p;
  logic [30:0]          z;
  logic [15:0]          frac;
  logic [3:0]           cnt;
  logic signed [EW-1:0] pk, env;
  logic [38:0]          x2;
  logic [36:0]          acc;
  logic [26:0]          gr;
  logic [12:0]          red;
  logic [18:0]          e;
  logic [24:0]          g;
  logic [27:0]          total;
  logic [SB-1:0]        res_l, res_r;
  logic                 clip;

  // output register
  logic                 out_valid;
  logic [SB-1:0]        out_l, out_r;
  logic [12:0]          out_red;
  logic                 out_clip;

  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;

  logic              accept, hand_over;
  logic [SB-1:0]     in_mag_l, in_mag_r;
  logic [P_W-1:0]    msb;
  logic [63:0]       zfull;
  logic [31:0]       sq;
  logic [NEG_W-1:0]  neg_oct;
  logic [47:0]       db_mag;
  logic signed [EW-1:0] pk_calc;
  logic              rising;
  logic [EW-1:0]     dmag;
  logic [23:0]       coeff;
  logic signed [EW-1:0] thr;
  logic signed [EW:0]   diff;
  logic [16:0]       slope;
  logic [56:0]       knee_sum;
  logic [27:0]       red_wide;
  logic [47:0]       e_wide;
  logic [24:0]       g_sh;
  logic [63:0]       y_sum;
  logic [Y_W-1:0]    y;
  logic [Y_W-1:0]    lim;
  logic              y_sat;
  logic [SB-1:0]     y_out;
  logic              cur_neg;

  assign accept    = in_ch.valid && in_ch.ready;
  assign hand_over = (state == skc_pkg::ST_DONE) && (!out_valid || out_ch.ready);

  assign prod = {32'b0, mul_a} * {32'b0, mul_b};

  // magnitudes and leading-one search
  always_comb begin
    in_mag_l = in_ch.sample_left[SB-1] ? SB'(-in_ch.sample_left) : in_ch.sample_left;
    in_mag_r = in_ch.sample_right[SB-1] ? SB'(-in_ch.sample_right) : in_ch.sample_right;
    msb = '0;
    for (int i = 0; i < SB; i++) begin
      if (mag_l[i]) msb = P_W'(i);
    end
    zfull = ({{(64-SB){1'b0}}, mag_l} << 30) >> msb;
  end

  // derived values for the current step
  always_comb begin
    sq       = prod[61:30];
    neg_oct  = NEG_W'({P_W'(SB-1) - p, 16'b0}) - NEG_W'(frac);
    db_mag   = 48'(prod + 64'd32768 >> 16);
    if (zero_l) begin
      pk_calc = skc_pkg::DB_FLOOR;
    end else if (p == P_W'(SB-1)) begin
      pk_calc = '0;
    end else if (db_mag > 48'd6553600) begin
      pk_calc = skc_pkg::DB_FLOOR;
    end else begin
      pk_calc = -EW'($signed({1'b0, db_mag[EW-2:0]}));
    end
    rising = pk > env;
    coeff  = rising ? attack_coeff : release_coeff;
    dmag   = rising ? EW'(pk - env) : EW'(env - pk);
    thr    = EW'($signed({threshold_db, 8'b0}));
    diff   = (EW+1)'(env) - (EW+1)'(thr);
    slope  = 17'd65536 - 17'(inverse_ratio);
    knee_sum = {acc, 19'b0} + 57'(prod);
    red_wide = 28'(({1'b0, gr} + 28'd128) >> 8);
    e_wide   = 48'(prod + 64'd32768 >> 16);
    g_sh     = g >> e[18:16];
    cur_neg  = (state == skc_pkg::ST_OUT_L) ? neg_l : neg_r;
    y_sum    = prod + 64'd8388608;
    y        = y_sum[Y_W+23:24];
    lim      = cur_neg ? Y_W'({1'b1, {(SB-1){1'b0}}}) : Y_W'({1'b0, {(SB-1){1'b1}}});
    y_sat    = y > lim;
    y_out    = y_sat ? SB'(lim) : SB'(y);
    if (cur_neg) y_out = SB'(-y_out);
  end

  // shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      skc_pkg::ST_SQUARE: begin mul_a = 32'(z); mul_b = 32'(z); end
      skc_pkg::ST_DB:     begin mul_a = 32'(neg_oct); mul_b = skc_pkg::DB_PER_OCTAVE; end
      skc_pkg::ST_ENV:    begin mul_a = 32'(coeff); mul_b = 32'(dmag); end
      skc_pkg::ST_KNEE: begin
        if (diff > (EW+1)'(262144)) begin
          mul_a = 32'(diff[EW-1:0]);
          mul_b = 32'(slope);
        end else begin
          mul_a = 32'(20'(diff + (EW+1)'(262144)));
          mul_b = 32'(20'(diff + (EW+1)'(262144)));
        end
      end
      skc_pkg::ST_GR_HI:  begin mul_a = 32'(x2[38:19]); mul_b = 32'(slope); end
      skc_pkg::ST_GR_LO:  begin mul_a = 32'(x2[18:0]); mul_b = 32'(slope); end
      skc_pkg::ST_EXP:    begin mul_a = 32'(red); mul_b = skc_pkg::OCTAVE_PER_DB; end
      skc_pkg::ST_GAIN:   begin mul_a = 32'(g); mul_b = 32'(skc_pkg::exp2_neg(cnt)); end
      skc_pkg::ST_TOTAL:  begin mul_a = 32'(g_sh); mul_b = 32'(output_gain); end
      skc_pkg::ST_OUT_L:  begin mul_a = 32'(mag_l); mul_b = 32'(total); end
      skc_pkg::ST_OUT_R:  begin mul_a = 32'(mag_r); mul_b = 32'(total); end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) state <= skc_pkg::ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next  = state;
    in_ch.ready = (state == skc_pkg::ST_IDLE);
    case (state)
      skc_pkg::ST_IDLE:   if (in_ch.valid) state_next = skc_pkg::ST_NORM;
      skc_pkg::ST_NORM:   state_next = skc_pkg::ST_SQUARE;
      skc_pkg::ST_SQUARE: if (cnt == 4'd15) state_next = skc_pkg::ST_DB;
      skc_pkg::ST_DB:     state_next = skc_pkg::ST_ENV;
      skc_pkg::ST_ENV:    state_next = skc_pkg::ST_KNEE;
      skc_pkg::ST_KNEE: begin
        if (diff > (EW+1)'(262144) || diff <= -(EW+1)'(262144)) begin
          state_next = skc_pkg::ST_RED;
        end else begin
          state_next = skc_pkg::ST_GR_HI;
        end
      end
      skc_pkg::ST_GR_HI:  state_next = skc_pkg::ST_GR_LO;
      skc_pkg::ST_GR_LO:  state_next = skc_pkg::ST_RED;
      skc_pkg::ST_RED:    state_next = skc_pkg::ST_EXP;
      skc_pkg::ST_EXP:    state_next = skc_pkg::ST_GAIN;
      skc_pkg::ST_GAIN:   if (cnt == 4'd15) state_next = skc_pkg::ST_TOTAL;
      skc_pkg::ST_TOTAL:  state_next = skc_pkg::ST_OUT_L;
      skc_pkg::ST_OUT_L:  state_next = skc_pkg::ST_OUT_R;
      skc_pkg::ST_OUT_R:  state_next = skc_pkg::ST_DONE;
      skc_pkg::ST_DONE:   if (hand_over) state_next = skc_pkg::ST_IDLE;
      default:            state_next = skc_pkg::ST_IDLE;
    endcase
  end

  // configuration and envelope state
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold_db  <= skc_pkg::THRESHOLD_RST;
      inverse_ratio <= skc_pkg::INV_RATIO_RST;
      output_gain   <= skc_pkg::OUT_GAIN_RST;
      attack_coeff  <= skc_pkg::ATTACK_RST;
      release_coeff <= skc_pkg::RELEASE_RST;
      channel_count <= skc_pkg::CHANNELS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        skc_pkg::CFG_THRESHOLD: threshold_db  <= cfg_data[14:0];
        skc_pkg::CFG_INV_RATIO: inverse_ratio <= cfg_data[15:0];
        skc_pkg::CFG_OUT_GAIN:  output_gain   <= cfg_data[15:0];
        skc_pkg::CFG_ATTACK:    attack_coeff  <= cfg_data[23:0];
        skc_pkg::CFG_RELEASE:   release_coeff <= cfg_data[23:0];
        skc_pkg::CFG_CHANNELS:  channel_count <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      env <= skc_pkg::DB_FLOOR;
    end else if (state == skc_pkg::ST_ENV) begin
      // truncation toward zero of coeff*(env-peak)
      env <= rising ? pk - EW'(prod[47:24]) : pk + EW'(prod[47:24]);
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      skc_pkg::ST_IDLE: begin
        if (accept) begin
          mag_l <= in_mag_l;
          mag_r <= in_mag_r;
          neg_l <= in_ch.sample_left[SB-1];
          neg_r <= in_ch.sample_right[SB-1];
        end
      end
      skc_pkg::ST_NORM: begin
        zero_l <= (mag_l == '0);
        p      <= msb;
        z      <= zfull[30:0];
        frac   <= '0;
        cnt    <= '0;
      end
      skc_pkg::ST_SQUARE: begin
        frac <= {frac[14:0], sq[31]};
        z    <= sq[31] ? sq[31:1] : sq[30:0];
        cnt  <= cnt + 4'd1;
      end
      skc_pkg::ST_DB:     pk <= pk_calc;
      skc_pkg::ST_KNEE: begin
        x2 <= prod[38:0];
        if (diff > (EW+1)'(262144)) gr <= prod[42:16];
        else                        gr <= '0;
      end
      skc_pkg::ST_GR_HI:  acc <= prod[36:0];
      skc_pkg::ST_GR_LO:  gr  <= 27'(knee_sum[56:36]);
      skc_pkg::ST_RED:    red <= (red_wide > 28'(skc_pkg::RED_MAX)) ? skc_pkg::RED_MAX
                                                                     : red_wide[12:0];
      skc_pkg::ST_EXP: begin
        e   <= e_wide[18:0];
        g   <= 25'h1000000;
        cnt <= '0;
      end
      skc_pkg::ST_GAIN: begin
        if (e[4'd15 - cnt]) g <= prod[48:24];
        cnt <= cnt + 4'd1;
      end
      skc_pkg::ST_TOTAL:  total <= prod[39:12];
      skc_pkg::ST_OUT_L: begin
        res_l <= y_out;
        clip  <= y_sat;
      end
      skc_pkg::ST_OUT_R: begin
        if (channel_count >= 2'd2) begin
          res_r <= y_out;
          clip  <= clip | y_sat;
        end else begin
          res_r <= '0;
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (hand_over) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (hand_over) begin
      out_l    <= res_l;
      out_r    <= res_r;
      out_red  <= red;
      out_clip <= clip;
    end
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.out_left     = out_l;
  assign out_ch.out_right    = out_r;
  assign out_ch.reduction_db = out_red;
  assign out_ch.clipped      = out_clip;

endmodule

FILE: src/skc_checker.sv
// Port-level checker of the soft-knee compressor, bound to the top level.
module skc_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [skc_pkg::SAMPLE_BITS-1:0] out_left,
  input logic [skc_pkg::SAMPLE_BITS-1:0] out_right,
  input logic                           clipped
);

  // one frame at a time: no accept right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while busy");

  a_clip_at_rail: assert property (@(posedge clk) disable iff (rst)
    out_valid && clipped |->
      out_left == skc_pkg::SAMPLE_MAX || out_left == skc_pkg::SAMPLE_MIN ||
      out_right == skc_pkg::SAMPLE_MAX || out_right == skc_pkg::SAMPLE_MIN)
    else $error("clipped without a saturated output");

  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid && in_ready)
    else $error("reset did not clear the handshake");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_left) && $stable(out_right))
    else $error("stalled result beat changed");

endmodule

bind soft_knee_compressor_top skc_checker u_skc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_left  (out_ch.out_left),
  .out_right (out_ch.out_right),
  .clipped   (out_ch.clipped)
);
